@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(name, clk, rst, prop)

`define ASSERT_NEVER(name, clk, rst, expr)

`endif

`endif

@@ rtl/bpa_pkg.sv @@
package bpa_pkg;

   localparam int INDEX_W     = 12;
   localparam int TOTAL_W     = 13;
   localparam int REF_W       = 8;
   localparam int INDEX_SPAN  = 4096;
   localparam int RECIP_SHIFT = 16;

   localparam logic [TOTAL_W-1:0] PAGE_TOTAL_RESET = 13'd4096;
   localparam logic [REF_W-1:0]   REF_MAX          = 8'hFF;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_RESERVE = 2'd2,
      CMD_QUERY   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

endpackage

@@ rtl/bpa_first_free.sv @@
module bpa_first_free
   import bpa_pkg::*;
#(
   parameter int WORD_BITS = 64,
   localparam int BIT_AW = $clog2(WORD_BITS)
) (
   input  logic [WORD_BITS-1:0] word,
   input  logic [TOTAL_W-1:0]   remain,
   output logic                 found,
   output logic [BIT_AW-1:0]    pos
);

   logic [WORD_BITS-1:0] free_bits;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         free_bits[b] = !word[b] && (TOTAL_W'(b) < remain);
      end
   end

   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            found = 1'b1;
            pos   = BIT_AW'(b);
         end
      end
   end

endmodule

@@ rtl/bitmap_page_allocator_top.sv @@
// First-fit page allocator over a used-page bitmap with an 8-bit saturating reference count per
// page. After reset the block sweeps its two memories, one page per cycle, over min(MAX_PAGES,
// 4096) pages; no beat is taken on the request side until the sweep is done, and all pages read
// as used, so pages become available only through free commands. Free, reserve and query with an
// index in range pass through S_DIV, S_FIX, S_READ and S_UPD to S_RESP, where the response is
// registered. Allocate reads one bitmap word of MAP_WORD_BITS pages per cycle over at most
// ceil(limit / MAP_WORD_BITS) words, where limit is page_total capped at the managed page count.
// A new request is taken once the previous response is in the output register.
`include "assert_macros.svh"

module bitmap_page_allocator_top
   import bpa_pkg::*;
#(
   parameter int MAX_PAGES     = 4096,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [TOTAL_W-1:0] csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [INDEX_W-1:0] req_page_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [INDEX_W-1:0] rsp_result_index,
   output logic [1:0]         rsp_status,
   output logic [REF_W-1:0]   rsp_ref_after
);

   localparam int PAGES   = (MAX_PAGES < INDEX_SPAN) ? MAX_PAGES : INDEX_SPAN;
   localparam int WORDS   = (PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PAGE_AW = $clog2(PAGES);
   localparam int BIT_AW  = $clog2(MAP_WORD_BITS);
   localparam int RECIP   = (1 << RECIP_SHIFT) / MAP_WORD_BITS;
   localparam int PROD_W  = INDEX_W + RECIP_SHIFT;
   localparam int CHK_W   = TOTAL_W + 1;

   typedef enum logic [7:0] {
      S_INIT = 8'b0000_0001,
      S_IDLE = 8'b0000_0010,
      S_DIV  = 8'b0000_0100,
      S_FIX  = 8'b0000_1000,
      S_SCAN = 8'b0001_0000,
      S_READ = 8'b0010_0000,
      S_UPD  = 8'b0100_0000,
      S_RESP = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [PAGE_AW-1:0]   init_ptr_ff, init_ptr_in;
   logic [TOTAL_W-1:0]   page_total_ff;
   cmd_type              cmd_ff, cmd_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [WORD_AW-1:0]   issue_word_ff, issue_word_in;
   logic [TOTAL_W-1:0]   issue_base_ff, issue_base_in;
   logic [TOTAL_W-1:0]   issue_rem_ff, issue_rem_in;
   logic [WORD_AW-1:0]   chk_word_ff, chk_word_in;
   logic [TOTAL_W-1:0]   chk_base_ff, chk_base_in;
   logic [TOTAL_W-1:0]   chk_rem_ff, chk_rem_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [WORD_AW-1:0]   op_word_ff, op_word_in;
   logic [BIT_AW-1:0]    op_bit_ff, op_bit_in;
   logic [PAGE_AW-1:0]   op_page_ff, op_page_in;
   logic [INDEX_W-1:0]   pend_index_ff, pend_index_in;
   status_type           pend_status_ff, pend_status_in;
   logic [REF_W-1:0]     pend_ref_ff, pend_ref_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [REF_W-1:0]     rsp_ref_ff, rsp_ref_in;

   logic [MAP_WORD_BITS-1:0] map_mem [WORDS];
   logic [REF_W-1:0]         ref_mem [PAGES];
   logic [MAP_WORD_BITS-1:0] map_rd_ff;
   logic [REF_W-1:0]         ref_rd_ff;

   logic                     map_we;
   logic [WORD_AW-1:0]       map_waddr, map_raddr;
   logic [MAP_WORD_BITS-1:0] map_wdata;
   logic                     ref_we;
   logic [PAGE_AW-1:0]       ref_waddr, ref_raddr;
   logic [REF_W-1:0]         ref_wdata;

   logic [TOTAL_W-1:0]       limit;
   logic                     found;
   logic [BIT_AW-1:0]        found_pos;
   logic [TOTAL_W-1:0]       found_page;
   logic [INDEX_W-1:0]       quot0, quot, q_times_w, rem0, rem;
   logic [MAP_WORD_BITS-1:0] bit_mask;
   logic [REF_W-1:0]         ref_bumped;

   assign limit = (page_total_ff > TOTAL_W'(PAGES)) ? TOTAL_W'(PAGES) : page_total_ff;

   bpa_first_free #(
      .WORD_BITS (MAP_WORD_BITS)
   ) u_first_free (
      .word   (map_rd_ff),
      .remain (chk_rem_ff),
      .found  (found),
      .pos    (found_pos)
   );

   assign found_page = chk_base_ff + TOTAL_W'(found_pos);

   always_comb begin
      quot0     = prod_ff[PROD_W-1:RECIP_SHIFT];
      q_times_w = quot0 * INDEX_W'(MAP_WORD_BITS);
      rem0      = idx_ff - q_times_w;
      if (rem0 >= INDEX_W'(MAP_WORD_BITS)) begin
         quot = quot0 + INDEX_W'(1);
         rem  = rem0 - INDEX_W'(MAP_WORD_BITS);
      end else begin
         quot = quot0;
         rem  = rem0;
      end
   end

   assign bit_mask   = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1} << op_bit_ff;
   assign ref_bumped = (ref_rd_ff == REF_MAX) ? REF_MAX : ref_rd_ff + REF_W'(1);

   always_comb begin
      state_in       = state_ff;
      init_ptr_in    = init_ptr_ff;
      cmd_in         = cmd_ff;
      idx_in         = idx_ff;
      prod_in        = prod_ff;
      issue_word_in  = issue_word_ff;
      issue_base_in  = issue_base_ff;
      issue_rem_in   = issue_rem_ff;
      chk_word_in    = chk_word_ff;
      chk_base_in    = chk_base_ff;
      chk_rem_in     = chk_rem_ff;
      chk_valid_in   = chk_valid_ff;
      op_word_in     = op_word_ff;
      op_bit_in      = op_bit_ff;
      op_page_in     = op_page_ff;
      pend_index_in  = pend_index_ff;
      pend_status_in = pend_status_ff;
      pend_ref_in    = pend_ref_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_index_in   = rsp_index_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_ref_in     = rsp_ref_ff;
      map_we         = 1'b0;
      map_waddr      = op_word_ff;
      map_wdata      = map_rd_ff;
      map_raddr      = op_word_ff;
      ref_we         = 1'b0;
      ref_waddr      = op_page_ff;
      ref_wdata      = ref_rd_ff;
      ref_raddr      = op_page_ff;

      case (state_ff)
         S_INIT: begin
            ref_we    = 1'b1;
            ref_waddr = init_ptr_ff;
            ref_wdata = '0;
            if (init_ptr_ff < PAGE_AW'(WORDS)) begin
               map_we    = 1'b1;
               map_waddr = init_ptr_ff[WORD_AW-1:0];
               map_wdata = '1;
            end
            if (init_ptr_ff == PAGE_AW'(PAGES - 1)) begin
               state_in = S_IDLE;
            end else begin
               init_ptr_in = init_ptr_ff + PAGE_AW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = cmd_type'(req_cmd);
               idx_in        = req_page_index;
               pend_index_in = '0;
               pend_ref_in   = '0;
               if (cmd_type'(req_cmd) == CMD_ALLOC) begin
                  if (limit == '0) begin
                     pend_status_in = STATUS_EMPTY;
                     state_in       = S_RESP;
                  end else begin
                     issue_word_in = '0;
                     issue_base_in = '0;
                     issue_rem_in  = limit;
                     chk_valid_in  = 1'b0;
                     state_in      = S_SCAN;
                  end
               end else if (TOTAL_W'(req_page_index) >= limit) begin
                  pend_status_in = STATUS_RANGE;
                  state_in       = S_RESP;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            prod_in  = PROD_W'(idx_ff) * PROD_W'(RECIP);
            state_in = S_FIX;
         end
         S_FIX: begin
            op_word_in = quot[WORD_AW-1:0];
            op_bit_in  = rem[BIT_AW-1:0];
            op_page_in = idx_ff[PAGE_AW-1:0];
            state_in   = S_READ;
         end
         S_SCAN: begin
            map_raddr    = issue_word_ff;
            chk_word_in  = issue_word_ff;
            chk_base_in  = issue_base_ff;
            chk_rem_in   = issue_rem_ff;
            chk_valid_in = (issue_rem_ff != '0);
            if (issue_rem_ff != '0) begin
               issue_word_in = issue_word_ff + WORD_AW'(1);
               issue_base_in = issue_base_ff + TOTAL_W'(MAP_WORD_BITS);
               issue_rem_in  = (issue_rem_ff > TOTAL_W'(MAP_WORD_BITS)) ?
                               issue_rem_ff - TOTAL_W'(MAP_WORD_BITS) : '0;
            end
            if (chk_valid_ff) begin
               if (found) begin
                  op_word_in = chk_word_ff;
                  op_bit_in  = found_pos;
                  op_page_in = found_page[PAGE_AW-1:0];
                  state_in   = S_READ;
               end else if (chk_rem_ff <= TOTAL_W'(MAP_WORD_BITS)) begin
                  pend_status_in = STATUS_EMPTY;
                  state_in       = S_RESP;
               end
            end
         end
         S_READ: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            map_we = 1'b1;
            ref_we = 1'b1;
            case (cmd_ff)
               CMD_FREE: begin
                  map_wdata = map_rd_ff & ~bit_mask;
                  ref_wdata = '0;
               end
               CMD_QUERY: begin
                  map_wdata = map_rd_ff;
                  ref_wdata = ref_rd_ff;
               end
               default: begin
                  map_wdata = map_rd_ff | bit_mask;
                  ref_wdata = ref_bumped;
               end
            endcase
            pend_index_in  = INDEX_W'(op_page_ff);
            pend_status_in = STATUS_OK;
            pend_ref_in    = ref_wdata;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = pend_index_ff;
               rsp_status_in = pend_status_ff;
               rsp_ref_in    = pend_ref_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_ptr_ff   <= '0;
         page_total_ff <= PAGE_TOTAL_RESET;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ptr_ff  <= init_ptr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            page_total_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      idx_ff         <= idx_in;
      prod_ff        <= prod_in;
      issue_word_ff  <= issue_word_in;
      issue_base_ff  <= issue_base_in;
      issue_rem_ff   <= issue_rem_in;
      chk_word_ff    <= chk_word_in;
      chk_base_ff    <= chk_base_in;
      chk_rem_ff     <= chk_rem_in;
      op_word_ff     <= op_word_in;
      op_bit_ff      <= op_bit_in;
      op_page_ff     <= op_page_in;
      pend_index_ff  <= pend_index_in;
      pend_status_ff <= pend_status_in;
      pend_ref_ff    <= pend_ref_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_ref_ff     <= rsp_ref_in;
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[ref_waddr] <= ref_wdata;
      end
      ref_rd_ff <= ref_mem[ref_raddr];
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_ref_after    = rsp_ref_ff;

   `ASSERT_CLK(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
   `ASSERT_CLK(a_fail_zero, clock, reset,
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (rsp_index_ff == '0 && rsp_ref_ff == '0))
   `ASSERT_CLK(a_split_ok, clock, reset, (state_ff == S_READ) |->
      (CHK_W'(op_word_ff) * CHK_W'(MAP_WORD_BITS) + CHK_W'(op_bit_ff) == CHK_W'(op_page_ff)))
   `ASSERT_CLK(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready)
   `ASSERT_NEVER(a_no_write_in_scan, clock, reset, (map_we || ref_we) && state_ff == S_SCAN)

endmodule
